### hw/rtl/assert_macros.svh
// Assertion macros shared by the receiver RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define PUFR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define PUFR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/pufr_pkg.sv
// Types and constants for the page update frame receiver.
// Depends on nothing; used by the result interface, the frame tracker and the top level.
package pufr_pkg;

   typedef enum logic [1:0] {
      KIND_STAGED = 2'd0,
      KIND_COMMIT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   localparam logic [7:0] PREAMBLE_FIRST  = 8'h55;
   localparam logic [7:0] PREAMBLE_SECOND = 8'hAA;
   localparam logic       REPLY_ACK       = 1'b1;
   localparam logic       REPLY_NACK      = 1'b0;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [15:0] page_address;
      logic [7:0]  offset;
      logic [7:0]  data_byte;
      logic        reply_byte;
   } result_type;

   // Sync header: 0x55, 0xAA, then a walking one from bit 0 that wraps every 8 bytes.
   function automatic logic [7:0] expected_preamble(input logic [3:0] pos);
      logic [3:0] rel;
      rel = pos - 4'd2;
      case (pos)
         4'd0:    expected_preamble = PREAMBLE_FIRST;
         4'd1:    expected_preamble = PREAMBLE_SECOND;
         default: expected_preamble = 8'd1 << rel[2:0];
      endcase
   endfunction

endpackage

### hw/rtl/pufr_req_if.sv
// Input channel: one received link byte per word.
// Depends on nothing; the payload is a plain byte.
interface pufr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/pufr_rsp_if.sv
// Result channel: staged data bytes and commit/reject verdicts.
// Depends on pufr_pkg for the kind type.
interface pufr_rsp_if;
   import pufr_pkg::*;

   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [15:0] page_address;
   logic [7:0]  offset;
   logic [7:0]  data_byte;
   logic        reply_byte;

   modport source (output valid, output kind, output page_address, output offset,
                   output data_byte, output reply_byte, input ready);
   modport sink   (input valid, input kind, input page_address, input offset,
                   input data_byte, input reply_byte, output ready);
endinterface

### hw/rtl/pufr_frame_tracker.sv
// Frame position counter, preamble check, address capture and XOR check.
// Depends on pufr_pkg; produces the result word for the byte being accepted.
module pufr_frame_tracker #(
   parameter int PAGE_BYTES     = 256,
   parameter int PREAMBLE_BYTES = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   output pufr_pkg::result_type result
);
   import pufr_pkg::*;

   localparam int ADDR_POS  = PREAMBLE_BYTES;
   localparam int DATA_POS  = PREAMBLE_BYTES + 2;
   localparam int CHECK_POS = PREAMBLE_BYTES + 2 + PAGE_BYTES;
   localparam int CNT_W     = $clog2(CHECK_POS + 1);
   localparam int PRE_W     = (PREAMBLE_BYTES > 1) ? $clog2(PREAMBLE_BYTES) : 1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             good_ff, good_in;
   logic [15:0]      addr_ff, addr_in;
   logic [7:0]       xor_ff, xor_in;
   logic [CNT_W-1:0] data_rel;

   assign data_rel = count_ff - CNT_W'(DATA_POS);

   always_comb begin
      count_in = count_ff + CNT_W'(1);
      good_in  = good_ff;
      addr_in  = addr_ff;
      xor_in   = xor_ff;
      result   = '0;
      result.page_address = addr_ff;

      if (count_ff < CNT_W'(ADDR_POS)) begin
         if (rx_byte != expected_preamble(4'(count_ff[PRE_W-1:0]))) begin
            good_in = 1'b0;
         end
      end else if (count_ff < CNT_W'(DATA_POS)) begin
         addr_in = {addr_ff[7:0], rx_byte};
      end else if (count_ff < CNT_W'(CHECK_POS)) begin
         xor_in = xor_ff ^ rx_byte;
         result.valid     = good_ff;
         result.kind      = KIND_STAGED;
         result.offset    = 8'(data_rel);
         result.data_byte = rx_byte;
      end else begin
         // check byte: verdict, then back to the start of a frame
         result.valid = good_ff;
         if (rx_byte == xor_ff) begin
            result.kind       = KIND_COMMIT;
            result.reply_byte = REPLY_ACK;
         end else begin
            result.kind       = KIND_REJECT;
            result.reply_byte = REPLY_NACK;
         end
         count_in = '0;
         good_in  = 1'b1;
         xor_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         good_ff  <= 1'b1;
         addr_ff  <= '0;
         xor_ff   <= '0;
      end else if (step) begin
         count_ff <= count_in;
         good_ff  <= good_in;
         addr_ff  <= addr_in;
         xor_ff   <= xor_in;
      end
   end

endmodule

### hw/rtl/page_update_frame_receiver.sv
// Page update frame receiver. Takes one link byte per cycle on req_chan while
// req_chan.ready is high; a frame is PREAMBLE_BYTES sync bytes, a big-endian page
// address, PAGE_BYTES data bytes and an XOR check byte. With a good preamble each
// data byte comes out on rsp_chan as a staged word, and the check byte gives a
// commit (ack) or reject (nack) word. A byte passes through the frame tracker logic
// into the result register and appears in the next cycle. req_chan.ready drops
// only while the result register holds a word that rsp_chan has not taken.
// Depends on pufr_pkg, pufr_req_if, pufr_rsp_if and pufr_frame_tracker.
`include "assert_macros.svh"

module page_update_frame_receiver #(
   parameter int PAGE_BYTES     = 256,
   parameter int PREAMBLE_BYTES = 10
) (
   input logic       clock,
   input logic       reset,
   pufr_req_if.sink  req_chan,
   pufr_rsp_if.source rsp_chan
);
   import pufr_pkg::*;

   logic       accept;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_word_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   pufr_frame_tracker #(
      .PAGE_BYTES     (PAGE_BYTES),
      .PREAMBLE_BYTES (PREAMBLE_BYTES)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .rx_byte (req_chan.rx_byte),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (accept) begin
         rsp_valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && result.valid) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_word_ff.kind;
   assign rsp_chan.page_address = rsp_word_ff.page_address;
   assign rsp_chan.offset       = rsp_word_ff.offset;
   assign rsp_chan.data_byte    = rsp_word_ff.data_byte;
   assign rsp_chan.reply_byte   = rsp_word_ff.reply_byte;

   `PUFR_ASSERT(a_backpressure, clock, reset, (rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready, "input taken while result word is stalled")
   `PUFR_ASSERT(a_verdict_clean, clock, reset, (rsp_valid_ff && rsp_chan.kind != KIND_STAGED) |-> (rsp_chan.offset == 8'd0 && rsp_chan.data_byte == 8'd0), "verdict word carries data")
   `PUFR_ASSERT(a_reply_match, clock, reset, rsp_valid_ff |-> ((rsp_chan.kind == KIND_COMMIT) == (rsp_chan.reply_byte == REPLY_ACK)), "reply byte disagrees with kind")
   `PUFR_ASSERT_NEXT(a_idle_drain, clock, reset, (!accept && (!rsp_valid_ff || rsp_chan.ready)), !rsp_valid_ff, "result word appeared without input")

endmodule

### sim/pufr_frame_checker.sv
// Frame checker for the page update frame receiver: predicts every result word
// from the accepted link bytes and compares it with what the result channel delivers.
// Depends on pufr_pkg and the pufr_req_if / pufr_rsp_if interfaces.
`timescale 1ns / 100ps

module pufr_frame_checker #(
   parameter int PAGE_BYTES     = 256,
   parameter int PREAMBLE_BYTES = 10
) (
   input  logic clock,
   input  logic reset,
   pufr_req_if  req_chan,
   pufr_rsp_if  rsp_chan,
   output int   mismatches,
   output int   pending_words
);
   import pufr_pkg::*;

   localparam int ADDR_START  = PREAMBLE_BYTES;
   localparam int DATA_START  = PREAMBLE_BYTES + 2;
   localparam int CHECK_START = PREAMBLE_BYTES + 2 + PAGE_BYTES;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] page_address;
      logic [7:0]  offset;
      logic [7:0]  data_byte;
      logic        reply_byte;
   } page_word_t;

   page_word_t  expected_words[$];
   logic [8:0]  frame_pos;
   logic        sync_ok;
   logic [15:0] page_addr;
   logic [7:0]  data_parity;
   int          fail_count;

   initial begin
      mismatches    = 0;
      pending_words = 0;
      fail_count    = 0;
   end

   // 0x55, 0xAA, then a walking one that wraps every eight bytes
   function automatic logic [7:0] sync_byte(input int pos);
      if (pos == 0) begin
         return PREAMBLE_FIRST;
      end else if (pos == 1) begin
         return PREAMBLE_SECOND;
      end
      return 8'h01 << ((pos - 2) % 8);
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      page_word_t want;
      page_word_t got;
      logic [7:0] b;
      if (reset) begin
         frame_pos   = '0;
         sync_ok     = 1'b1;
         page_addr   = '0;
         data_parity = '0;
         expected_words.delete();
      end else begin
         // result side first: a word taken at this edge belongs to an older byte
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.kind, rsp_chan.page_address, rsp_chan.offset,
                    rsp_chan.data_byte, rsp_chan.reply_byte};
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word, expected none, got %p", $time, got);
            end else begin
               want = expected_words.pop_front();
               check_field("kind", want.kind, got.kind);
               check_field("page_address", want.page_address, got.page_address);
               check_field("offset", want.offset, got.offset);
               check_field("data_byte", want.data_byte, got.data_byte);
               check_field("reply_byte", want.reply_byte, got.reply_byte);
            end
         end

         if (req_chan.valid && req_chan.ready) begin
            b = req_chan.rx_byte;
            if (frame_pos < ADDR_START) begin
               if (b != sync_byte(frame_pos)) begin
                  sync_ok = 1'b0;
               end
               frame_pos++;
            end else if (frame_pos < DATA_START) begin
               page_addr = {page_addr[7:0], b};
               frame_pos++;
            end else if (frame_pos < CHECK_START) begin
               data_parity ^= b;
               if (sync_ok) begin
                  expected_words.push_back('{KIND_STAGED, page_addr,
                                             8'(frame_pos - DATA_START), b, 1'b0});
               end
               frame_pos++;
            end else begin
               if (sync_ok) begin
                  if (b == data_parity) begin
                     expected_words.push_back('{KIND_COMMIT, page_addr, 8'h00, 8'h00,
                                                REPLY_ACK});
                  end else begin
                     expected_words.push_back('{KIND_REJECT, page_addr, 8'h00, 8'h00,
                                                REPLY_NACK});
                  end
               end
               frame_pos   = '0;
               sync_ok     = 1'b1;
               data_parity = '0;
            end
         end
      end
      mismatches    <= fail_count;
      pending_words <= expected_words.size();
   end

endmodule

### sim/tb.sv
// Testbench top for the page update frame receiver: clock, reset, frame stimulus
// with idle and stall phases, and the final verdict.
// Depends on pufr_pkg, the channel interfaces, the receiver and pufr_frame_checker.
`timescale 1ns / 100ps

module tb;
   import pufr_pkg::*;

   localparam int PAGE_BYTES     = 256;
   localparam int PREAMBLE_BYTES = 10;
   localparam int FILL_RANDOM    = 0;
   localparam int FILL_EXTREMES  = 1;
   localparam int FILL_RAMP      = 2;
   localparam int NO_BAD_SYNC    = -1;

   logic clock = 1'b0;
   logic reset;
   int   send_idle;
   int   recv_stall;
   int   bytes_sent;
   int   mismatches;
   int   pending_words;

   pufr_req_if req_chan ();
   pufr_rsp_if rsp_chan ();

   page_update_frame_receiver #(
      .PAGE_BYTES    (PAGE_BYTES),
      .PREAMBLE_BYTES(PREAMBLE_BYTES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   pufr_frame_checker #(
      .PAGE_BYTES    (PAGE_BYTES),
      .PREAMBLE_BYTES(PREAMBLE_BYTES)
   ) u_frame_check (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .mismatches   (mismatches),
      .pending_words(pending_words)
   );

   always #4 clock = ~clock;

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall);
   end

   // One word on the input channel; idle and stall rates rotate every 200 words.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
      case ((bytes_sent / 200) % 4)
         0:       begin send_idle = 0;  recv_stall = 0;  end
         1:       begin send_idle = 57; recv_stall = 0;  end
         2:       begin send_idle = 0;  recv_stall = 57; end
         default: begin send_idle = 15; recv_stall = 15; end
      endcase
   endtask

   task automatic send_frame(input logic [15:0] addr, input int bad_pos, input int fill,
                             input bit bad_check);
      logic [7:0] walk;
      logic [7:0] parity;
      logic [7:0] b;
      walk   = 8'h01;
      parity = 8'h00;
      for (int i = 0; i < PREAMBLE_BYTES; i++) begin
         if (i == 0) begin
            b = PREAMBLE_FIRST;
         end else if (i == 1) begin
            b = PREAMBLE_SECOND;
         end else begin
            b    = walk;
            walk = {walk[6:0], walk[7]};
         end
         if (i == bad_pos) b ^= 8'($urandom_range(255, 1));
         send_byte(b);
      end
      send_byte(addr[15:8]);
      send_byte(addr[7:0]);
      for (int k = 0; k < PAGE_BYTES; k++) begin
         case (fill)
            FILL_EXTREMES: b = k[0] ? 8'hFF : 8'h00;
            FILL_RAMP:     b = k[7:0];
            default:       b = 8'($urandom);
         endcase
         parity ^= b;
         send_byte(b);
      end
      if (bad_check) parity ^= 8'($urandom_range(255, 1));
      send_byte(parity);
   endtask

   initial begin : stimulus
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready   = 1'b0;
      send_idle        = 0;
      recv_stall       = 0;
      bytes_sent       = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // address extremes with ack and nack, then a frame whose last sync byte is bad
      send_frame(16'hFFFF, NO_BAD_SYNC, FILL_EXTREMES, 1'b0);
      send_frame(16'h0000, NO_BAD_SYNC, FILL_RAMP, 1'b1);
      send_frame(16'h1234, PREAMBLE_BYTES - 1, FILL_RANDOM, 1'b0);
      req_chan.valid <= 1'b0;

      repeat (2) @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_words == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
